>>> design/twrr_pkg.sv
package twrr_pkg;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int DATA_BITS    = 32;
    localparam int WEIGHT_BITS  = 8;
    localparam int PTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_BITS    = PTR_BITS + 1;
    localparam int MEM_DEPTH    = 2 ** ADDR_BITS;
    localparam int SLOT_BITS    = WEIGHT_BITS + 2;

    localparam logic REG_WEIGHT_A = 1'b0;
    localparam logic REG_WEIGHT_B = 1'b1;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic FLOW_A = 1'b0;
    localparam logic FLOW_B = 1'b1;

    typedef struct packed {
        logic                 we;
        logic [ADDR_BITS-1:0] waddr;
        logic                 re;
        logic [ADDR_BITS-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                done;
        logic                served;
        logic                served_flow;
        logic                dropped;
        logic [CNT_BITS-1:0] count_a;
        logic [CNT_BITS-1:0] count_b;
        logic                all_empty;
    } result_t;

endpackage

>>> design/twrr_ram.sv
module twrr_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/twrr_sched.sv
module twrr_sched
    import twrr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic                   mode,
    input  logic                   flow,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [WEIGHT_BITS-1:0] cfg_data,
    output mem_req_t               mem_req,
    output result_t                result
);

    logic [WEIGHT_BITS-1:0] weight_a_reg, weight_a_next;
    logic [WEIGHT_BITS-1:0] weight_b_reg, weight_b_next;
    logic [SLOT_BITS-1:0]   slot_reg, slot_next;
    logic [PTR_BITS-1:0]    head_a_reg, head_a_next, tail_a_reg, tail_a_next;
    logic [PTR_BITS-1:0]    head_b_reg, head_b_next, tail_b_reg, tail_b_next;
    logic [CNT_BITS-1:0]    fill_a_reg, fill_a_next, fill_b_reg, fill_b_next;
    result_t                result_reg, result_next;

    logic [SLOT_BITS-1:0] sum_w;
    logic                 favour_a;
    logic                 full_a;
    logic                 full_b;
    logic                 push_a;
    logic                 push_b;
    logic                 take_a;
    logic                 take_b;
    logic                 drop;

    function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS:0] inc;
        inc = {1'b0, p} + 1'b1;
        return (inc >= (PTR_BITS+1)'(QUEUE_DEPTH)) ? '0 : inc[PTR_BITS-1:0];
    endfunction

    function automatic logic [SLOT_BITS-1:0] wrap_slot(
        input logic [SLOT_BITS-1:0] s,
        input logic [SLOT_BITS-1:0] limit
    );
        return (s > limit) ? SLOT_BITS'(1) : s;
    endfunction

    always_comb
    begin
        sum_w    = SLOT_BITS'(weight_a_reg) + SLOT_BITS'(weight_b_reg);
        favour_a = slot_reg <= SLOT_BITS'(weight_a_reg);
        full_a   = fill_a_reg >= CNT_BITS'(QUEUE_DEPTH);
        full_b   = fill_b_reg >= CNT_BITS'(QUEUE_DEPTH);

        push_a = go && (mode == MODE_PUSH) && (flow == FLOW_A) && !full_a;
        push_b = go && (mode == MODE_PUSH) && (flow == FLOW_B) && !full_b;
        drop   = go && (mode == MODE_PUSH) && ((flow == FLOW_A) ? full_a : full_b);

        take_a    = 1'b0;
        take_b    = 1'b0;
        slot_next = slot_reg;
        if (go && (mode == MODE_POP))
        begin
            priority if (favour_a && (fill_a_reg != '0))
            begin
                take_a    = 1'b1;
                slot_next = wrap_slot(slot_reg + 1'b1, sum_w);
            end
            else if (favour_a && (fill_b_reg != '0))
            begin
                take_b    = 1'b1;
                slot_next = wrap_slot(SLOT_BITS'(weight_a_reg) + SLOT_BITS'(2), sum_w);
            end
            else if (!favour_a && (fill_b_reg != '0))
            begin
                take_b    = 1'b1;
                slot_next = wrap_slot(slot_reg + 1'b1, sum_w);
            end
            else if (!favour_a && (fill_a_reg != '0))
            begin
                take_a    = 1'b1;
                slot_next = wrap_slot(SLOT_BITS'(2), sum_w);
            end
        end

        tail_a_next = push_a ? next_ptr(tail_a_reg) : tail_a_reg;
        tail_b_next = push_b ? next_ptr(tail_b_reg) : tail_b_reg;
        head_a_next = take_a ? next_ptr(head_a_reg) : head_a_reg;
        head_b_next = take_b ? next_ptr(head_b_reg) : head_b_reg;

        fill_a_next = fill_a_reg;
        if (push_a)
        begin
            fill_a_next = fill_a_reg + 1'b1;
        end
        else if (take_a)
        begin
            fill_a_next = fill_a_reg - 1'b1;
        end
        fill_b_next = fill_b_reg;
        if (push_b)
        begin
            fill_b_next = fill_b_reg + 1'b1;
        end
        else if (take_b)
        begin
            fill_b_next = fill_b_reg - 1'b1;
        end

        weight_a_next = weight_a_reg;
        weight_b_next = weight_b_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WEIGHT_A: weight_a_next = cfg_data;
                REG_WEIGHT_B: weight_b_next = cfg_data;
                default:      weight_a_next = weight_a_reg;
            endcase
        end

        // shared memory: queue a in the lower half, queue b in the upper half
        mem_req.we    = push_a || push_b;
        mem_req.waddr = {flow, (flow == FLOW_B) ? tail_b_reg : tail_a_reg};
        mem_req.re    = take_a || take_b;
        mem_req.raddr = {take_b, take_b ? head_b_reg : head_a_reg};

        result_next.done        = go;
        result_next.served      = take_a || take_b;
        result_next.served_flow = take_b;
        result_next.dropped     = drop;
        result_next.count_a     = fill_a_next;
        result_next.count_b     = fill_b_next;
        result_next.all_empty   = (fill_a_next == '0) && (fill_b_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_a_reg <= WEIGHT_BITS'(1);
            weight_b_reg <= WEIGHT_BITS'(1);
            slot_reg     <= SLOT_BITS'(1);
            head_a_reg   <= '0;
            tail_a_reg   <= '0;
            head_b_reg   <= '0;
            tail_b_reg   <= '0;
            fill_a_reg   <= '0;
            fill_b_reg   <= '0;
            result_reg   <= '0;
        end
        else
        begin
            weight_a_reg <= weight_a_next;
            weight_b_reg <= weight_b_next;
            slot_reg     <= slot_next;
            head_a_reg   <= head_a_next;
            tail_a_reg   <= tail_a_next;
            head_b_reg   <= head_b_next;
            tail_b_reg   <= tail_b_next;
            fill_a_reg   <= fill_a_next;
            fill_b_reg   <= fill_b_next;
            result_reg   <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> design/two_queue_weighted_round_robin.sv
// the result of a request appears on the result ports in the cycle after it is accepted
// throughput: one request per cycle, set by the registered update of the queue memory
// busy stays low; the result strobe done is high for exactly one cycle per request
// reset clears queue pointers and counts, sets the slot counter and both weights to 1
// the queue memory is not cleared and needs no clearing pass
module two_queue_weighted_round_robin
    import twrr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   mode,
    input  logic                   flow,
    input  logic [DATA_BITS-1:0]   client_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [WEIGHT_BITS-1:0] cfg_data,
    output logic                   done,
    output logic                   served,
    output logic                   served_flow,
    output logic [DATA_BITS-1:0]   served_data,
    output logic                   dropped,
    output logic [CNT_BITS-1:0]    count_a,
    output logic [CNT_BITS-1:0]    count_b,
    output logic                   all_empty
);

    mem_req_t                mem_req;
    result_t                 result;
    logic [PAYLOAD_BITS-1:0] rdata;
    logic                    go;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign go        = start && !busy;

    twrr_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .mode      (mode),
        .flow      (flow),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .result    (result)
    );

    twrr_ram #(
        .DEPTH (MEM_DEPTH),
        .WIDTH (PAYLOAD_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (PAYLOAD_BITS'(client_data)),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    assign done        = result.done;
    assign served      = result.served;
    assign served_flow = result.served_flow;
    assign served_data = result.served ? DATA_BITS'(rdata) : '0;
    assign dropped     = result.dropped;
    assign count_a     = result.count_a;
    assign count_b     = result.count_b;
    assign all_empty   = result.all_empty;

endmodule
